// File: rtl/cbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator package
// Field widths, status codes and default sizes shared by the channel
// interfaces and the allocator.
// ----------------------------------------------------------------------------
package cbpa_pkg;

    localparam int NUM_CHUNKS_DEF       = 8;
    localparam int BLOCKS_PER_CHUNK_DEF = 200;

    localparam int W_REQ_TYPE = 1;
    localparam int W_CHUNK    = 3;
    localparam int W_SLOT     = 8;
    localparam int W_STATUS   = 2;

    localparam logic [W_REQ_TYPE-1:0] REQ_ALLOC = 1'b0;
    localparam logic [W_REQ_TYPE-1:0] REQ_FREE  = 1'b1;

    localparam logic [W_STATUS-1:0] ST_OK        = 2'd0;
    localparam logic [W_STATUS-1:0] ST_OOM       = 2'd1;
    localparam logic [W_STATUS-1:0] ST_NOT_OWNED = 2'd2;
    localparam logic [W_STATUS-1:0] ST_FULL      = 2'd3;

endpackage

// File: rtl/cbpa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one allocate or free request per beat.
// ----------------------------------------------------------------------------
interface cbpa_req_if;
    import cbpa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [W_REQ_TYPE-1:0] req_type;
    logic                  is_null;
    logic [W_CHUNK-1:0]    chunk_index;
    logic [W_SLOT-1:0]     slot_index;

    modport source (
        output valid, req_type, is_null, chunk_index, slot_index,
        input  ready
    );

    modport sink (
        input  valid, req_type, is_null, chunk_index, slot_index,
        output ready
    );

endinterface

// File: rtl/cbpa_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one status and block handle per beat.
// ----------------------------------------------------------------------------
interface cbpa_res_if;
    import cbpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [W_STATUS-1:0] status;
    logic [W_CHUNK-1:0]  got_chunk;
    logic [W_SLOT-1:0]   got_slot;

    modport source (
        output valid, status, got_chunk, got_slot,
        input  ready
    );

    modport sink (
        input  valid, status, got_chunk, got_slot,
        output ready
    );

endinterface

// File: rtl/chunked_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked block pool allocator
// Fixed-size blocks in chunks, each chunk with a LIFO free stack held in a
// shared stack memory, driven by a small sequencer and one address adder.
//
//   Port    Dir   Beat content
//   i_req   in    req_type, is_null, chunk_index, slot_index
//   o_res   out   status, got_chunk, got_slot
//
// A null or rejected free answers from idle; a valid free reads its chunk,
// then pushes in S_FREE. An allocate scans one chunk per cycle from chunk 0,
// pops from the first non-empty one, else activates the next chunk and
// fills its stack, else reports out of memory. Reset clears only state,
// active count, non-empty flags and result valid. A request is taken in
// idle while the result register is empty or its beat leaves in that cycle.
// ----------------------------------------------------------------------------
module chunked_block_pool_allocator #(
    parameter int NUM_CHUNKS       = cbpa_pkg::NUM_CHUNKS_DEF,
    parameter int BLOCKS_PER_CHUNK = cbpa_pkg::BLOCKS_PER_CHUNK_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cbpa_req_if.sink        i_req,
    cbpa_res_if.source      o_res
);
    import cbpa_pkg::*;

    localparam int W_CNT  = $clog2(NUM_CHUNKS + 1);
    localparam int W_CH   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int W_SL   = (BLOCKS_PER_CHUNK > 1) ? $clog2(BLOCKS_PER_CHUNK) : 1;
    localparam int W_FILL = $clog2(BLOCKS_PER_CHUNK + 1);
    localparam int DEPTH  = NUM_CHUNKS * BLOCKS_PER_CHUNK;
    localparam int W_ADDR = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [W_SL-1:0]   SL_LAST  = W_SL'(BLOCKS_PER_CHUNK - 1);
    localparam logic [W_FILL-1:0] FILL_MAX = W_FILL'(BLOCKS_PER_CHUNK);
    localparam logic [W_CNT-1:0]  CNT_MAX  = W_CNT'(NUM_CHUNKS);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SCAN      = 3'd1;
    localparam logic [2:0] S_POP       = 3'd2;
    localparam logic [2:0] S_POP_OUT   = 3'd3;
    localparam logic [2:0] S_FILL      = 3'd4;
    localparam logic [2:0] S_FREE_WAIT = 3'd5;
    localparam logic [2:0] S_FREE      = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [W_CNT-1:0]      r_active, n_active;
    logic [NUM_CHUNKS-1:0] r_nz, n_nz;
    logic [W_CNT-1:0]      r_ch, n_ch;
    logic [W_SL-1:0]       r_idx, n_idx;
    logic [W_SL-1:0]       r_sl, n_sl;
    logic [W_ADDR-1:0]     r_base;
    logic [W_FILL-1:0]     r_fill_rd;
    logic [W_SL-1:0]       r_stk_rd;
    logic                  r_out_valid, n_out_valid;
    logic [W_STATUS-1:0]   r_out_status, n_out_status;
    logic [W_CHUNK-1:0]    r_out_chunk, n_out_chunk;
    logic [W_SLOT-1:0]     r_out_slot, n_out_slot;

    logic [W_FILL-1:0] mem_fill [NUM_CHUNKS];
    logic [W_SL-1:0]   mem_stk  [DEPTH];

    logic              w_in_ready;
    logic              w_owned;
    logic [W_CH-1:0]   w_ch;
    logic [W_ADDR-1:0] w_off;
    logic [W_ADDR-1:0] w_addr;
    logic              fill_we;
    logic [W_FILL-1:0] fill_wd;
    logic              stk_we;
    logic [W_SL-1:0]   stk_wd;

    assign w_ch    = r_ch[W_CH-1:0];
    assign w_owned = ((W_CNT + W_CHUNK)'(i_req.chunk_index) < (W_CNT + W_CHUNK)'(r_active))
                  && (32'(i_req.slot_index) < 32'(BLOCKS_PER_CHUNK));

    always_comb begin
        unique case (r_state)
            S_FILL:  w_off = W_ADDR'(r_idx);
            S_FREE:  w_off = W_ADDR'(r_fill_rd);
            default: w_off = W_ADDR'(r_fill_rd - 1'b1);
        endcase
    end

    assign w_addr = r_base + w_off;

    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_nz         = r_nz;
        n_ch         = r_ch;
        n_idx        = r_idx;
        n_sl         = r_sl;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_chunk  = r_out_chunk;
        n_out_slot   = r_out_slot;
        fill_we      = 1'b0;
        fill_wd      = r_fill_rd;
        stk_we       = 1'b0;
        stk_wd       = r_sl;
        w_in_ready   = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid && w_in_ready) begin
                    if (i_req.req_type == REQ_ALLOC) begin
                        n_ch    = '0;
                        n_state = S_SCAN;
                    end else if (i_req.is_null || !w_owned) begin
                        n_out_valid  = 1'b1;
                        n_out_status = i_req.is_null ? ST_OK : ST_NOT_OWNED;
                        n_out_chunk  = '0;
                        n_out_slot   = '0;
                    end else begin
                        n_ch    = W_CNT'(i_req.chunk_index);
                        n_sl    = W_SL'(i_req.slot_index);
                        n_state = S_FREE_WAIT;
                    end
                end
            end
            S_SCAN: begin
                if (r_ch == r_active) begin
                    if (r_active != CNT_MAX) begin
                        n_active = r_active + 1'b1;
                        n_idx    = '0;
                        n_state  = S_FILL;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_OOM;
                        n_out_chunk  = '0;
                        n_out_slot   = '0;
                        n_state      = S_IDLE;
                    end
                end else if (r_nz[w_ch]) begin
                    n_state = S_POP;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            S_POP: begin
                fill_we    = 1'b1;
                fill_wd    = r_fill_rd - 1'b1;
                n_nz[w_ch] = (fill_wd != '0);
                n_state    = S_POP_OUT;
            end
            S_POP_OUT: begin
                n_out_valid  = 1'b1;
                n_out_status = ST_OK;
                n_out_chunk  = W_CHUNK'(r_ch);
                n_out_slot   = W_SLOT'(r_stk_rd);
                n_state      = S_IDLE;
            end
            S_FILL: begin
                stk_we = 1'b1;
                stk_wd = r_idx;
                if (r_idx == SL_LAST) begin
                    fill_we      = 1'b1;
                    fill_wd      = FILL_MAX - 1'b1;
                    n_nz[w_ch]   = (fill_wd != '0);
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_chunk  = W_CHUNK'(r_ch);
                    n_out_slot   = W_SLOT'(SL_LAST);
                    n_state      = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FREE_WAIT: begin
                n_state = S_FREE;
            end
            S_FREE: begin
                n_out_valid = 1'b1;
                n_out_chunk = '0;
                n_out_slot  = '0;
                if (r_fill_rd >= FILL_MAX) begin
                    n_out_status = ST_FULL;
                end else begin
                    stk_we       = 1'b1;
                    fill_we      = 1'b1;
                    fill_wd      = r_fill_rd + 1'b1;
                    n_nz[w_ch]   = 1'b1;
                    n_out_status = ST_OK;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_nz        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_nz        <= n_nz;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch         <= n_ch;
        r_idx        <= n_idx;
        r_sl         <= n_sl;
        r_base       <= W_ADDR'(32'(w_ch) * 32'(BLOCKS_PER_CHUNK));
        r_out_status <= n_out_status;
        r_out_chunk  <= n_out_chunk;
        r_out_slot   <= n_out_slot;
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            mem_fill[w_ch] <= fill_wd;
        end
        r_fill_rd <= mem_fill[w_ch];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            mem_stk[w_addr] <= stk_wd;
        end
        r_stk_rd <= mem_stk[w_addr];
    end

    assign i_req.ready     = w_in_ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_out_status;
    assign o_res.got_chunk = r_out_chunk;
    assign o_res.got_slot  = r_out_slot;

endmodule
